/* rtl/core/multi_wave_lfo_assert.svh */
// assertion macros for the multi-wave oscillator
// no dependencies; taken in by the rtl files that carry checks
`ifndef MULTI_WAVE_LFO_ASSERT_SVH
`define MULTI_WAVE_LFO_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define MWL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("multi_wave_lfo: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define MWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("multi_wave_lfo: next-cycle check failed");

`endif

/* rtl/core/mwlfo_pkg.sv */
// types, constants and helpers for the multi-wave oscillator
// no dependencies
package mwlfo_pkg;

    localparam int PHASE_BITS_DEF = 32;

    typedef logic [1:0]         wave_t;
    typedef logic signed [15:0] sample_t;
    typedef logic [1:0]         cfg_index_t;
    typedef logic [31:0]        cfg_data_t;

    // register indexes
    localparam cfg_index_t REG_PHASE_STEP   = 2'd0;
    localparam cfg_index_t REG_SMOOTH_STEPS = 2'd1;

    // wave codes
    localparam wave_t WAVE_SINE     = 2'd0;
    localparam wave_t WAVE_TRIANGLE = 2'd1;
    localparam wave_t WAVE_SAW      = 2'd2;
    localparam wave_t WAVE_SQUARE   = 2'd3;

    // quarter-sine polynomial constants
    localparam logic [15:0] SINE_C0  = 16'd10583;
    localparam logic [10:0] SINE_C1  = 11'd1302;
    localparam logic [15:0] SINE_C2  = 16'd25736;
    localparam logic [14:0] QUARTER  = 15'd16384;

    localparam sample_t Q15_MAX = 16'sh7FFF;
    localparam sample_t Q15_MIN = -16'sh8000;

    localparam int DIV_STEPS = 16;

    function automatic sample_t sat_q15(input logic signed [17:0] v);
        sample_t r;
        if (v > 18'sd32767)
            r = Q15_MAX;
        else if (v < -18'sd32768)
            r = Q15_MIN;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

/* rtl/core/multi_wave_lfo.sv */
// multi_wave_lfo: an accepted item steps through S_WAVE, for sine S_SQ to S_MD, then S_DIFF,
// S_DIV and S_FIN, which raises sample valid; the next item is accepted in the cycle after
// that, later while the previous sample is still waiting at the output
// the sequence is set by the 16-step restoring divider and the shared 15x15 multiplier
// that runs the four sine polynomial products in turn; one item in flight at a time
// rst_n (async, active low) clears phase, last target, phase step and sets ramp length 1
`include "multi_wave_lfo_assert.svh"

module multi_wave_lfo #(
    parameter int PHASE_BITS = mwlfo_pkg::PHASE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  mwlfo_pkg::cfg_index_t  cfg_index,
    input  mwlfo_pkg::cfg_data_t   cfg_data,
    input  logic                   wave_valid,
    output logic                   wave_ready,
    input  mwlfo_pkg::wave_t       wave,
    output logic                   sample_valid,
    input  logic                   sample_ready,
    output mwlfo_pkg::sample_t     sample
);
    import mwlfo_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WAVE = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_MA   = 4'd3;
    localparam logic [3:0] S_MB   = 4'd4;
    localparam logic [3:0] S_MC   = 4'd5;
    localparam logic [3:0] S_MD   = 4'd6;
    localparam logic [3:0] S_DIFF = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [3:0]            state_reg, state_next;
    logic [31:0]           phase_step_reg;
    logic [15:0]           smooth_steps_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    sample_t               last_target_reg;
    wave_t                 wave_reg;
    logic [14:0]           x_reg;
    logic [14:0]           x2_reg;
    logic                  quad_neg_reg;
    logic [29:0]           prod_reg;
    sample_t               raw_reg;
    logic                  neg_reg;
    logic [15:0]           divisor_reg;
    logic [15:0]           rem_reg;
    logic [15:0]           quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  sample_valid_reg;
    sample_t               sample_reg;

    logic [15:0]           u;
    logic signed [17:0]    two_u;
    sample_t               wave_raw;
    logic [14:0]           x_fold;
    logic [14:0]           mul_a, mul_b;
    logic [29:0]           mul_p;
    logic [15:0]           t_val, t2_val;
    logic [16:0]           s_val;
    sample_t               sine_mag;
    logic signed [16:0]    diff;
    logic [16:0]           diff_mag;
    logic [16:0]           rem_shift;
    logic [16:0]           rem_sub;
    logic                  q_bit;
    logic signed [17:0]    q_signed;
    logic signed [17:0]    sum;
    logic                  out_free;

    assign cfg_ready    = 1'b1;
    assign wave_ready   = (state_reg == S_IDLE);
    assign sample_valid = sample_valid_reg;
    assign sample       = sample_reg;
    assign out_free     = !sample_valid_reg || sample_ready;

    // top 16 bits of the freshly advanced phase
    assign u     = phase_reg[PHASE_BITS-1 -: 16];
    assign two_u = signed'({1'b0, u, 1'b0});

    always_comb
    begin
        unique case (wave_reg)
            WAVE_TRIANGLE:
            begin
                if (u < 16'd16384)
                    wave_raw = sat_q15(two_u);
                else if (u < 16'd49152)
                    wave_raw = sat_q15(18'sd65536 - two_u);
                else
                    wave_raw = sat_q15(two_u - 18'sd131072);
            end
            WAVE_SAW:    wave_raw = {~u[15], u[14:0]};
            WAVE_SQUARE: wave_raw = u[15] ? Q15_MIN : Q15_MAX;
            default:     wave_raw = '0;
        endcase
    end

    // odd quadrants run the quarter wave backwards
    assign x_fold = u[14] ? (QUARTER - {1'b0, u[13:0]}) : {1'b0, u[13:0]};

    assign t_val  = SINE_C0 - prod_reg[29:14];
    assign t2_val = SINE_C2 - prod_reg[29:14];
    assign s_val  = prod_reg[29:13];
    assign sine_mag = (s_val > 17'd32767) ? Q15_MAX : s_val[15:0];

    // shared multiplier, operands chosen by the sequencer
    always_comb
    begin
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            S_MA:
            begin
                mul_a = prod_reg[28:14];
                mul_b = {4'd0, SINE_C1};
            end
            S_MB:
            begin
                mul_a = x2_reg;
                mul_b = t_val[14:0];
            end
            S_MC:
            begin
                mul_a = x_reg;
                mul_b = t2_val[14:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign diff     = 17'(signed'({raw_reg[15], raw_reg}) - signed'({last_target_reg[15],
                      last_target_reg}));
    assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);

    // one restoring step per cycle
    assign rem_shift = {rem_reg, quo_reg[15]};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign q_bit     = (rem_shift >= {1'b0, divisor_reg});

    assign q_signed = neg_reg ? -signed'({2'b00, quo_reg}) : signed'({2'b00, quo_reg});
    assign sum      = signed'({{2{last_target_reg[15]}}, last_target_reg}) + q_signed;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (wave_valid) state_next = S_WAVE;
            S_WAVE: state_next = (wave_reg == WAVE_SINE) ? S_SQ : S_DIFF;
            S_SQ:   state_next = S_MA;
            S_MA:   state_next = S_MB;
            S_MB:   state_next = S_MC;
            S_MC:   state_next = S_MD;
            S_MD:   state_next = S_DIFF;
            S_DIFF: state_next = S_DIV;
            S_DIV:  if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_step_reg   <= '0;
            smooth_steps_reg <= 16'd1;
            phase_reg        <= '0;
            last_target_reg  <= '0;
            sample_valid_reg <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PHASE_STEP)
                    phase_step_reg <= cfg_data;
                else if (cfg_index == REG_SMOOTH_STEPS)
                    smooth_steps_reg <= cfg_data[15:0];
            end
            if (wave_valid && wave_ready)
                phase_reg <= phase_reg + PHASE_BITS'(phase_step_reg);
            if (state_reg == S_DIFF)
                cnt_reg <= '0;
            else if (state_reg == S_DIV)
                cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == S_FIN && out_free)
            begin
                sample_valid_reg <= 1'b1;
                last_target_reg  <= raw_reg;
            end
            else if (sample_valid_reg && sample_ready)
                sample_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wave_valid && wave_ready)
            wave_reg <= wave;
        unique case (state_reg)
            S_WAVE:
            begin
                x_reg        <= x_fold;
                quad_neg_reg <= u[15];
                raw_reg      <= wave_raw;
            end
            S_SQ, S_MB, S_MC:
                prod_reg <= mul_p;
            S_MA:
            begin
                x2_reg   <= prod_reg[28:14];
                prod_reg <= mul_p;
            end
            S_MD:
                raw_reg <= quad_neg_reg ? -sine_mag : sine_mag;
            S_DIFF:
            begin
                neg_reg     <= diff[16];
                quo_reg     <= diff_mag[15:0];
                rem_reg     <= '0;
                divisor_reg <= (smooth_steps_reg == 16'd0) ? 16'd1 : smooth_steps_reg;
            end
            S_DIV:
            begin
                rem_reg <= q_bit ? rem_sub[15:0] : rem_shift[15:0];
                quo_reg <= {quo_reg[14:0], q_bit};
            end
            S_FIN:
                if (out_free)
                    sample_reg <= sat_q15(sum);
            default:
            begin
            end
        endcase
    end

    `MWL_ASSERT_NEXT(a_accept_starts, clk, rst_n, wave_valid && wave_ready,
        state_reg == S_WAVE)
    `MWL_ASSERT_NOW(a_rem_below_div, clk, rst_n, state_reg == S_DIV,
        rem_reg < divisor_reg)
    `MWL_ASSERT_NOW(a_x_in_quarter, clk, rst_n, state_reg == S_SQ,
        x_reg <= QUARTER)
    `MWL_ASSERT_NEXT(a_fin_delivers, clk, rst_n, (state_reg == S_FIN) && out_free,
        sample_valid_reg && (state_reg == S_IDLE))
    `MWL_ASSERT_NOW(a_div_nonzero, clk, rst_n, state_reg == S_DIV,
        divisor_reg != 16'd0)

endmodule

/* dv/multi_wave_lfo_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for multi_wave_lfo: directed corners, then randomised waves
// over many phase-step and ramp-length settings; depends on mwlfo_pkg and the rtl only
module multi_wave_lfo_tb;
    import mwlfo_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 103;

    // indexes that decode to no register
    localparam cfg_index_t REG_SPARE_A = 2'd2;
    localparam cfg_index_t REG_SPARE_B = 2'd3;

    typedef struct {
        wave_t       wave;
        sample_t     value;
        int unsigned seq;
    } sample_expect_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;
    logic       wave_valid;
    logic       wave_ready;
    wave_t      wave;
    logic       sample_valid;
    logic       sample_ready;
    sample_t    sample;

    // predictor state and register copies
    logic [31:0] model_phase;
    logic [31:0] model_step;
    logic [15:0] model_ramp_len;
    int          model_last_raw;

    sample_expect_t expected_samples[$];
    sample_expect_t head;

    int unsigned items_sent;
    int unsigned samples_checked;
    int unsigned config_writes;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned stall_left;
    bit          tx_gaps_on;
    bit          rx_stalls_on;

    multi_wave_lfo DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .wave_valid   (wave_valid),
        .wave_ready   (wave_ready),
        .wave         (wave),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic sample_t clamp_q15(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return -16'sh8000;
        return sample_t'(v);
    endfunction

    function automatic int quarter_sine(input int x);
        int sq;
        int t;
        int t2;
        sq = (x * x) >>> 14;
        t  = 10583 - ((sq * 1302) >>> 14);
        t2 = 25736 - ((sq * t) >>> 14);
        return int'(clamp_q15((x * t2) >>> 13));
    endfunction

    function automatic int wave_raw(input wave_t w, input logic [15:0] u);
        int iu;
        int x;
        int s;
        iu = int'(u);
        case (w)
            WAVE_SINE:
            begin
                x = int'(u[13:0]);
                if (u[14])
                    x = 16384 - x;
                s = quarter_sine(x);
                return u[15] ? -s : s;
            end
            WAVE_TRIANGLE:
            begin
                if (iu < 16384)
                    return int'(clamp_q15(2 * iu));
                if (iu < 49152)
                    return int'(clamp_q15(65536 - 2 * iu));
                return int'(clamp_q15(2 * iu - 131072));
            end
            WAVE_SAW:
                return iu - 32768;
            default:
                return (iu < 32768) ? 32767 : -32768;
        endcase
    endfunction

    // advances the phase, forms the wave and takes the first ramp step
    function automatic sample_t predict_sample(input wave_t w);
        int raw;
        int steps;
        int ramp;
        model_phase = model_phase + model_step;
        raw   = wave_raw(w, model_phase[31:16]);
        steps = (model_ramp_len == 16'd0) ? 1 : int'(model_ramp_len);
        ramp  = model_last_raw + (raw - model_last_raw) / steps;
        model_last_raw = raw;
        return clamp_q15(ramp);
    endfunction

    function automatic int unsigned gap_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned pick_tx_gap();
        if (!tx_gaps_on || $urandom_range(0, 99) < 50)
            return 0;
        return gap_length();
    endfunction

    // called and returning at a falling edge; valid is left high when the next item
    // follows at once, so the caller ends a burst with end_burst
    task automatic send_wave(input wave_t w);
        int unsigned gap;
        wave_valid <= 1'b1;
        wave       <= w;
        do
            @(posedge clk);
        while (!wave_ready);
        expected_samples.push_back('{w, predict_sample(w), items_sent});
        items_sent++;
        @(negedge clk);
        gap = pick_tx_gap();
        if (gap != 0)
        begin
            wave_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic end_burst();
        if (wave_valid)
            wave_valid <= 1'b0;
    endtask

    // lets every outstanding item come back before the block is reconfigured
    task automatic settle();
        end_burst();
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PHASE_STEP:   model_step     = data;
            REG_SMOOTH_STEPS: model_ramp_len = data[15:0];
            default:          ;
        endcase
        config_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        // phase step of zero after reset keeps the phase at the start of the cycle
        send_wave(WAVE_SINE);
        send_wave(WAVE_TRIANGLE);
        send_wave(WAVE_SAW);
        send_wave(WAVE_SQUARE);
        settle();
    endtask

    task automatic test_wave_corners();
        wave_t seq[12];
        seq = '{WAVE_SINE, WAVE_SINE, WAVE_SINE, WAVE_SINE,
                WAVE_TRIANGLE, WAVE_TRIANGLE, WAVE_TRIANGLE, WAVE_TRIANGLE,
                WAVE_SAW, WAVE_SQUARE, WAVE_SQUARE, WAVE_SAW};
        // quarter-cycle steps land on every quadrant boundary, peaks saturate
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_SMOOTH_STEPS, 32'd1);
        foreach (seq[i])
            send_wave(seq[i]);
        settle();
    endtask

    task automatic test_ramp_extremes();
        // zero ramp length behaves as one
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_SMOOTH_STEPS, 32'd0);
        send_wave(WAVE_SAW);
        send_wave(WAVE_SQUARE);
        settle();
        write_reg(REG_SMOOTH_STEPS, 32'h0000_FFFF);
        send_wave(WAVE_SQUARE);
        send_wave(WAVE_SINE);
        settle();
        // full-scale swings halved
        write_reg(REG_PHASE_STEP, 32'h8000_0000);
        write_reg(REG_SMOOTH_STEPS, 32'd2);
        send_wave(WAVE_SQUARE);
        send_wave(WAVE_SQUARE);
        settle();
    endtask

    task automatic test_unknown_register();
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, $urandom);
        send_wave(WAVE_TRIANGLE);
        send_wave(WAVE_SAW);
        settle();
    endtask

    function automatic cfg_data_t pick_phase_step();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3, 4:    return $urandom_range(1, 32'h00FF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic cfg_data_t pick_ramp_len();
        cfg_data_t d;
        d = $urandom;
        case ($urandom_range(0, 9))
            0:          d[15:0] = 16'd0;
            1:          d[15:0] = 16'd1;
            2:          d[15:0] = 16'hFFFF;
            3:          d[15:0] = 16'd2;
            4, 5, 6:    d[15:0] = 16'($urandom_range(1, 16));
            default:    ;
        endcase
        return d;
    endfunction

    task automatic test_random_sweep();
        wave_t held;
        bit    hold_wave;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // first phase runs flat out, second with sender gaps only
            tx_gaps_on   = (p != 0);
            rx_stalls_on = (p > 1);
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            if (p == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_PHASE_STEP, pick_phase_step());
            if (p == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_SMOOTH_STEPS, pick_ramp_len());
            hold_wave = ($urandom_range(0, 1) != 0);
            held      = wave_t'($urandom_range(0, 3));
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_wave(hold_wave ? held : wave_t'($urandom_range(0, 3)));
            settle();
        end
    endtask

    // receiver side: random stalls, mostly short
    initial
    begin
        sample_ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
                sample_ready <= 1'b0;
            end
            else if (rx_stalls_on && $urandom_range(0, 99) < 20)
            begin
                stall_left = gap_length() - 1;
                sample_ready <= 1'b0;
            end
            else
                sample_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sample_valid && sample_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                error_count++;
                $display("%0t ERROR unexpected sample: expected none actual %0d",
                         $time, sample);
            end
            else
            begin
                head = expected_samples.pop_front();
                samples_checked++;
                if (sample !== head.value)
                begin
                    error_count++;
                    $display("%0t ERROR item %0d wave %0d: expected %0d actual %0d",
                             $time, head.seq, head.wave, head.value, sample);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ERROR timeout after %0d cycles", $time, cycle_count);
        $display("FAIL multi_wave_lfo");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_PHASE_STEP;
        cfg_data        = '0;
        wave_valid      = 1'b0;
        wave            = WAVE_SINE;
        model_phase     = '0;
        model_step      = '0;
        model_ramp_len  = 16'd1;
        model_last_raw  = 0;
        items_sent      = 0;
        samples_checked = 0;
        config_writes   = 0;
        error_count     = 0;
        tx_gaps_on      = 1'b0;
        rx_stalls_on    = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        test_wave_corners();
        test_ramp_extremes();
        test_unknown_register();
        test_random_sweep();

        repeat (40) @(negedge clk);
        $display("covered %0d items over four waves and %0d register writes",
                 items_sent, config_writes);
        $display("samples checked %0d, mismatches %0d", samples_checked, error_count);
        if (error_count == 0 && expected_samples.size() == 0)
            $display("PASS multi_wave_lfo");
        else
            $display("FAIL multi_wave_lfo");
        $finish;
    end

endmodule
